/* sv/sbda_pkg.sv */
// Package: widths, ASCII codes, the word handed along the digit chain, decade constants.
package sbda_pkg;

  localparam int NUM_W    = 32;
  localparam int CHAR_W   = 7;
  localparam int DIGITS   = 10;
  localparam int DIGIT_W  = 4;
  localparam int COUNT_W  = 4;
  // 9 * 10^9 needs 34 bits; keep some margin
  localparam int MULT_W   = 36;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;

  typedef struct packed {
    logic                             neg;
    logic [NUM_W-1:0]                 rem;
    logic [COUNT_W-1:0]               count;   // significant digits found so far
    logic [DIGITS-1:0][DIGIT_W-1:0]   digits;  // digits[k] weighs 10^k
  } sbda_word_t;

  // j * 10^pos, evaluated on constants only
  function automatic logic [MULT_W-1:0] dec_mult(input int pos, input int j);
    logic [MULT_W-1:0] v;
    v = MULT_W'(j);
    for (int k = 0; k < pos; k++) begin
      v = v * MULT_W'(10);
    end
    return v;
  endfunction

endpackage

/* sv/sbda_if.sv */
// Stream interfaces: number input channel and character result channel.
interface sbda_num_if;
  import sbda_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [NUM_W-1:0] number;
  modport source(output valid, output number, input ready);
  modport sink(input valid, input number, output ready);
endinterface

interface sbda_char_if;
  import sbda_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last_char;
  modport source(output valid, output character, output last_char, input ready);
  modport sink(input valid, input character, input last_char, output ready);
endinterface

/* sv/signed_binary_to_decimal_ascii_unit.sv */
// Top level: input register, chain of ten digit cells, character serializer.
// A number is taken into an input register that forms its magnitude, then walks
// through ten registered digit cells (10^9 down to 10^0), each of which holds it
// while the next is not ready, and on to the serializer. Characters leave at one
// per cycle while the result channel is ready; a number's text has 1 to 11
// characters, and this serializer sets the sustained rate. Up to eleven further
// numbers are held in flight in the chain meanwhile. The magnitude of the most
// negative value is taken as 2147483648.
module signed_binary_to_decimal_ascii_unit (
  input  logic        clk,
  input  logic        rst_n,
  sbda_num_if.sink    in_chan,
  sbda_char_if.source out_chan
);
  import sbda_pkg::*;

  logic       valid_c [0:DIGITS];
  logic       ready_c [0:DIGITS];
  sbda_word_t word_c  [0:DIGITS];

  logic       entry_valid_r;
  sbda_word_t entry_r;
  sbda_word_t entry_nxt;

  always_comb begin
    entry_nxt        = '0;
    entry_nxt.neg    = in_chan.number[NUM_W-1];
    entry_nxt.rem    = in_chan.number[NUM_W-1] ? (~in_chan.number[NUM_W-1:0] + NUM_W'(1))
                                               : in_chan.number[NUM_W-1:0];
  end

  assign in_chan.ready = !entry_valid_r || ready_c[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      entry_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      entry_r <= entry_nxt;
    end
  end

  assign valid_c[0] = entry_valid_r;
  assign word_c[0]  = entry_r;

  for (genvar i = 0; i < DIGITS; i++) begin : g_cell
    sbda_digit_cell #(
      .POS(DIGITS-1-i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (valid_c[i]),
      .in_ready (ready_c[i]),
      .in_word  (word_c[i]),
      .out_valid(valid_c[i+1]),
      .out_ready(ready_c[i+1]),
      .out_word (word_c[i+1])
    );
  end

  sbda_serializer u_ser (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(valid_c[DIGITS]),
    .in_ready(ready_c[DIGITS]),
    .in_word (word_c[DIGITS]),
    .out_chan(out_chan)
  );

endmodule

/* sv/sbda_digit_cell.sv */
// One cell of the digit chain: extracts the digit of weight 10^POS and passes the remainder on.
module sbda_digit_cell #(
  parameter int POS = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sbda_pkg::sbda_word_t in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output sbda_pkg::sbda_word_t out_word
);
  import sbda_pkg::*;

  logic [MULT_W-1:0]  mult [0:9];
  logic [MULT_W-1:0]  rem_ext;
  logic [MULT_W-1:0]  rem_sub;
  logic [DIGIT_W-1:0] digit;
  sbda_word_t         word_nxt;
  sbda_word_t         word_r;
  logic               valid_r;

  always_comb begin
    for (int j = 0; j < 10; j++) begin
      mult[j] = dec_mult(POS, j);
    end
  end

  // multiples rise monotonically, so the last one that fits gives the digit
  always_comb begin
    rem_ext = {{(MULT_W-NUM_W){1'b0}}, in_word.rem};
    digit   = '0;
    for (int j = 1; j < 10; j++) begin
      if (rem_ext >= mult[j]) begin
        digit = DIGIT_W'(j);
      end
    end
  end

  always_comb begin
    rem_sub                = rem_ext - mult[digit];
    word_nxt               = in_word;
    word_nxt.rem           = rem_sub[NUM_W-1:0];
    word_nxt.digits[POS]   = digit;
    if (digit != '0 || in_word.count != '0) begin
      word_nxt.count = in_word.count + COUNT_W'(1);
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_word  = word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word_r <= word_nxt;
    end
  end

endmodule

/* sv/sbda_serializer.sv */
// Output stage: sends sign and significant digits of one word, one character per transfer.
module sbda_serializer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sbda_pkg::sbda_word_t in_word,
  sbda_char_if.source         out_chan
);
  import sbda_pkg::*;

  logic                           busy_r;
  logic                           sign_r;
  logic [DIGIT_W-1:0]             pos_r;
  logic [DIGITS-1:0][DIGIT_W-1:0] digits_r;
  logic                           is_last;
  logic                           out_xfer;
  logic                           load;

  assign is_last  = !sign_r && pos_r == '0;
  assign out_xfer = out_chan.valid && out_chan.ready;
  assign in_ready = !busy_r || (out_xfer && is_last);
  assign load     = in_ready && in_valid;

  assign out_chan.valid     = busy_r;
  assign out_chan.last_char = is_last;
  assign out_chan.character = sign_r ? ASCII_MINUS
                                     : ASCII_ZERO + CHAR_W'(digits_r[pos_r]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      sign_r <= 1'b0;
      pos_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      sign_r <= in_word.neg;
      // zero has no significant digit: send the units digit alone
      pos_r  <= (in_word.count == '0) ? '0 : DIGIT_W'(in_word.count - COUNT_W'(1));
    end else if (out_xfer) begin
      if (sign_r) begin
        sign_r <= 1'b0;
      end else if (pos_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        pos_r <= pos_r - DIGIT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      digits_r <= in_word.digits;
    end
  end

  a_sign_busy: assert property (@(posedge clk) disable iff (!rst_n)
    sign_r |-> busy_r)
    else $error("sign pending while idle");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> pos_r <= DIGIT_W'(DIGITS-1))
    else $error("digit position out of range");

  a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && !is_last |=> busy_r)
    else $error("text cut short");

  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.character == ASCII_MINUS |-> !out_chan.last_char)
    else $error("minus sign marked last");

endmodule
